/* hw/rtl/ach_pkg.sv */
// ----------------------------------------------------------------------------
// ach_pkg
// Shared types, codes and helpers for the adaptive compacting histogram.
// ----------------------------------------------------------------------------
package ach_pkg;

   typedef logic signed [31:0] key_type;
   typedef logic [31:0]        cnt_type;
   typedef logic [33:0]        scale_type;

   localparam logic [1:0] FN_ADD   = 2'd0;
   localparam logic [1:0] FN_READ  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic CSR_BASE    = 1'b0;
   localparam logic CSR_INIT_EXP = 1'b1;

   localparam scale_type SCALE_CAP = 34'h2_0000_0000;
   localparam logic [5:0] EXP_MAX  = 6'd63;

   // saturating 32-bit add
   function automatic cnt_type sat_add(input cnt_type a, input cnt_type b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

/* hw/rtl/ach_div.sv */
// ----------------------------------------------------------------------------
// ach_div
// Bit-serial floor division of a signed 32-bit value by an unsigned divisor.
// ----------------------------------------------------------------------------
module ach_div import ach_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  key_type   dividend,
   input  scale_type divisor,
   output logic      done,
   output key_type   quotient
);

   logic [31:0] mag_ff;
   logic [34:0] rem_ff;
   logic [33:0] den_ff;
   logic        neg_ff;
   logic [5:0]  step_ff;
   logic        run_ff;
   logic        done_ff;
   key_type     quo_ff;

   logic [34:0] rem_sh;
   logic [34:0] rem_sub;
   logic        take;
   logic [32:0] q_ext;
   logic [32:0] q_neg;

   assign rem_sh  = {rem_ff[33:0], mag_ff[31]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign take    = (rem_sh >= {1'b0, den_ff});
   assign q_ext   = {1'b0, mag_ff};
   // floor: round toward minus infinity on a nonzero remainder
   assign q_neg   = (33'd0 - q_ext) - {32'd0, (rem_ff != 35'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= 6'd0;
            mag_ff  <= dividend[31] ? 32'd0 - dividend : dividend;
            neg_ff  <= dividend[31];
            den_ff  <= divisor;
            rem_ff  <= 35'd0;
         end else if (run_ff) begin
            if (step_ff == 6'd32) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               quo_ff  <= neg_ff ? q_neg[31:0] : q_ext[31:0];
            end else begin
               rem_ff  <= take ? rem_sub : rem_sh;
               mag_ff  <= {mag_ff[30:0], take};
               step_ff <= step_ff + 6'd1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/adaptive_compacting_histogram_top.sv */
// ----------------------------------------------------------------------------
// adaptive_compacting_histogram_top
// Sorted-bin streaming histogram with compaction, held in one bin memory.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command on req_* with start high while busy is low; that edge
//   takes the beat. busy stays high until the result is issued. Each command
//   yields one result beat on rsp_*, marked by rsp_strobe for one cycle; the
//   receiver cannot stall it, so capture it on that edge.
//   An add runs the key division, walks the bins in the search and, on a
//   miss, moves bins up to open a slot for the new one; when the table is
//   full, a compaction pass first divides each bin's key by base (one
//   serial division per bin in use) and merges bins that meet, then the key
//   division and the search run again, or another pass runs if the table is
//   still full. A read walks the bins up to the index, and skips the walk
//   when the table is empty or the index is out of range.
//   The bin memory has one read and one write port with registered read data.
//   csr_* writes base (index 0) and initial_exponent (index 1); write them
//   only while busy is low. Reset empties the table, sets base to 2,
//   initial_exponent to 0 and the scale to 1; the memory is not swept.
// ----------------------------------------------------------------------------
module adaptive_compacting_histogram_top import ach_pkg::*; #(
   parameter int NUM_BINS = 64,
   localparam int AW = $clog2(NUM_BINS),
   localparam int CW = $clog2(NUM_BINS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_sample,
   input  logic [AW-1:0]       req_bin_index,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic [CW-1:0]       rsp_bins_used,
   output logic signed [33:0]  rsp_bin_lower,
   output logic [31:0]         rsp_bin_hits,
   output logic [31:0]         rsp_hits_before,
   output logic [31:0]         rsp_total_hits,
   output logic [5:0]          rsp_cur_exponent,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [15:0]         csr_wdata
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_KEY_GO   = 5'd1;
   localparam logic [4:0] S_KEY_WAIT = 5'd2;
   localparam logic [4:0] S_LOC_RD   = 5'd3;
   localparam logic [4:0] S_LOC_CHK  = 5'd4;
   localparam logic [4:0] S_MISS     = 5'd5;
   localparam logic [4:0] S_SH_RD    = 5'd6;
   localparam logic [4:0] S_SH_WR    = 5'd7;
   localparam logic [4:0] S_CP_RD    = 5'd8;
   localparam logic [4:0] S_CP_DATA  = 5'd9;
   localparam logic [4:0] S_CP_DIV   = 5'd10;
   localparam logic [4:0] S_CP_END   = 5'd11;
   localparam logic [4:0] S_CP_CHK   = 5'd12;
   localparam logic [4:0] S_RD_RD    = 5'd13;
   localparam logic [4:0] S_RD_DATA  = 5'd14;
   localparam logic [4:0] S_MUL1     = 5'd15;
   localparam logic [4:0] S_MUL2     = 5'd16;
   localparam logic [4:0] S_CLR      = 5'd17;
   localparam logic [4:0] S_RESP     = 5'd18;

   localparam logic [CW-1:0] FULL = CW'(NUM_BINS);

   // configuration
   logic [15:0] base_ff;
   logic [4:0]  init_ff;

   // table state
   logic [CW-1:0] used_ff;
   logic [5:0]    exp_ff;
   scale_type     scale_ff;
   cnt_type       total_ff;

   // per-command working registers
   logic [4:0]    state_ff;
   key_type       sample_ff;
   logic [AW-1:0] idx_ff;
   key_type       key_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] pos_ff;
   key_type       last_key_ff;
   cnt_type       last_cnt_ff;
   cnt_type       cnt_tmp_ff;
   cnt_type       sum_ff;
   cnt_type       hits_ff;
   logic signed [33:0] lower_ff;
   logic signed [49:0] plo_ff;
   logic signed [49:0] phi_ff;
   logic [1:0]    status_ff;
   logic [4:0]    e_ff;

   // result beat
   logic               rsp_strobe_ff;
   logic [1:0]         rsp_status_ff;
   logic [CW-1:0]      rsp_used_ff;
   logic signed [33:0] rsp_lower_ff;
   cnt_type            rsp_hits_ff;
   cnt_type            rsp_before_ff;
   cnt_type            rsp_total_ff;
   logic [5:0]         rsp_exp_ff;

   // bin memory: {key, count}
   logic [63:0]   mem [NUM_BINS];
   logic [63:0]   rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [63:0]   mem_wdata;
   logic [AW-1:0] mem_raddr;

   // divider
   logic      div_start;
   key_type   div_a;
   scale_type div_d;
   logic      div_done;
   key_type   div_q;

   key_type   rd_key;
   cnt_type   rd_cnt;
   logic [15:0] eff_base;
   logic [49:0] scale_prod;
   scale_type scale_next;
   cnt_type   inc_cnt;
   cnt_type   merge_cnt;
   logic      merge;
   logic [CW-1:0] i_dec;
   logic signed [66:0] prod_full;
   logic signed [33:0] lower_sat;

   assign rd_key    = rd_data_ff[63:32];
   assign rd_cnt    = rd_data_ff[31:0];
   assign eff_base  = (base_ff < 16'd2) ? 16'd2 : base_ff;
   assign scale_prod = {16'd0, scale_ff} * {34'd0, eff_base};
   assign scale_next = (scale_prod > {16'd0, SCALE_CAP}) ? SCALE_CAP : scale_prod[33:0];
   assign inc_cnt   = sat_add(rd_cnt, 32'd1);
   assign merge_cnt = sat_add(last_cnt_ff, cnt_tmp_ff);
   assign merge     = (n_ff != '0) && (last_key_ff == div_q);
   assign i_dec     = i_ff - CW'(1);

   // lower bound: key times scale, split in two halves of the scale
   assign prod_full = {{17{plo_ff[49]}}, plo_ff} + ({{17{phi_ff[49]}}, phi_ff} <<< 17);
   always_comb begin
      if (prod_full > 67'sd2147483647) begin
         lower_sat = 34'sd2147483647;
      end else if (prod_full < -67'sd8589934592) begin
         lower_sat = -34'sd8589934592;
      end else begin
         lower_sat = prod_full[33:0];
      end
   end

   ach_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   // divider launch and memory port control
   always_comb begin
      div_start = 1'b0;
      div_a     = sample_ff;
      div_d     = scale_ff;
      mem_we    = 1'b0;
      mem_waddr = i_ff[AW-1:0];
      mem_wdata = rd_data_ff;
      mem_raddr = (state_ff == S_SH_RD) ? i_dec[AW-1:0] : i_ff[AW-1:0];
      case (state_ff)
         S_KEY_GO: begin
            div_start = 1'b1;
         end
         S_CP_DATA: begin
            div_start = 1'b1;
            div_a     = rd_key;
            div_d     = {18'd0, eff_base};
         end
         S_LOC_CHK: begin
            // hit: bump the count in place
            mem_we    = (rd_key == key_ff);
            mem_wdata = {rd_key, inc_cnt};
         end
         S_SH_RD: begin
            // hole reached: drop the new bin in
            mem_we    = (i_ff == pos_ff);
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = {key_ff, 32'd1};
         end
         S_SH_WR: begin
            mem_we = 1'b1;
         end
         S_CP_DIV: begin
            mem_we = div_done;
            if (merge) begin
               mem_waddr = n_ff[AW-1:0] - AW'(1);
               mem_wdata = {div_q, merge_cnt};
            end else begin
               mem_waddr = n_ff[AW-1:0];
               mem_wdata = {div_q, cnt_tmp_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   // command sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= 16'd2;
         init_ff       <= 5'd0;
         used_ff       <= '0;
         exp_ff        <= 6'd0;
         scale_ff      <= 34'd1;
         total_ff      <= 32'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_BASE:     base_ff <= csr_wdata;
               CSR_INIT_EXP: init_ff <= csr_wdata[4:0];
               default:      base_ff <= base_ff;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  sample_ff <= req_sample;
                  idx_ff    <= req_bin_index;
                  status_ff <= ST_OK;
                  hits_ff   <= 32'd0;
                  sum_ff    <= 32'd0;
                  lower_ff  <= 34'sd0;
                  i_ff      <= '0;
                  case (req_func)
                     FN_ADD: begin
                        total_ff <= sat_add(total_ff, 32'd1);
                        state_ff <= S_KEY_GO;
                     end
                     FN_READ: begin
                        if (used_ff == '0) begin
                           status_ff <= ST_EMPTY;
                           state_ff  <= S_RESP;
                        end else if (CW'(req_bin_index) >= used_ff) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_RESP;
                        end else begin
                           state_ff <= S_RD_RD;
                        end
                     end
                     FN_CLEAR: begin
                        used_ff  <= '0;
                        total_ff <= 32'd0;
                        exp_ff   <= {1'b0, init_ff};
                        scale_ff <= 34'd1;
                        e_ff     <= 5'd0;
                        state_ff <= S_CLR;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_KEY_GO: state_ff <= S_KEY_WAIT;
            S_KEY_WAIT: begin
               if (div_done) begin
                  key_ff   <= div_q;
                  i_ff     <= '0;
                  state_ff <= S_LOC_RD;
               end
            end
            S_LOC_RD: begin
               if (i_ff == used_ff) begin
                  pos_ff   <= i_ff;
                  state_ff <= S_MISS;
               end else begin
                  state_ff <= S_LOC_CHK;
               end
            end
            S_LOC_CHK: begin
               if (rd_key == key_ff) begin
                  state_ff <= S_RESP;
               end else if (key_ff < rd_key) begin
                  pos_ff   <= i_ff;
                  state_ff <= S_MISS;
               end else begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_LOC_RD;
               end
            end
            S_MISS: begin
               if (used_ff == FULL) begin
                  i_ff     <= '0;
                  n_ff     <= '0;
                  state_ff <= S_CP_RD;
               end else begin
                  i_ff     <= used_ff;
                  state_ff <= S_SH_RD;
               end
            end
            S_SH_RD: begin
               if (i_ff == pos_ff) begin
                  used_ff  <= used_ff + CW'(1);
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_SH_WR;
               end
            end
            S_SH_WR: begin
               i_ff     <= i_dec;
               state_ff <= S_SH_RD;
            end
            S_CP_RD: begin
               state_ff <= (i_ff == used_ff) ? S_CP_END : S_CP_DATA;
            end
            S_CP_DATA: begin
               cnt_tmp_ff <= rd_cnt;
               state_ff   <= S_CP_DIV;
            end
            S_CP_DIV: begin
               if (div_done) begin
                  if (merge) begin
                     last_cnt_ff <= merge_cnt;
                  end else begin
                     last_key_ff <= div_q;
                     last_cnt_ff <= cnt_tmp_ff;
                     n_ff        <= n_ff + CW'(1);
                  end
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_CP_RD;
               end
            end
            S_CP_END: begin
               used_ff  <= n_ff;
               exp_ff   <= (exp_ff == EXP_MAX) ? EXP_MAX : exp_ff + 6'd1;
               scale_ff <= scale_next;
               state_ff <= S_CP_CHK;
            end
            S_CP_CHK: begin
               if (used_ff == FULL) begin
                  i_ff     <= '0;
                  n_ff     <= '0;
                  state_ff <= S_CP_RD;
               end else begin
                  state_ff <= S_KEY_GO;
               end
            end
            S_RD_RD: state_ff <= S_RD_DATA;
            S_RD_DATA: begin
               if (i_ff == CW'(idx_ff)) begin
                  hits_ff  <= rd_cnt;
                  key_ff   <= rd_key;
                  state_ff <= S_MUL1;
               end else begin
                  sum_ff   <= sat_add(sum_ff, rd_cnt);
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_RD_RD;
               end
            end
            S_MUL1: begin
               plo_ff   <= key_ff * $signed({1'b0, scale_ff[16:0]});
               phi_ff   <= key_ff * $signed({1'b0, scale_ff[33:17]});
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               lower_ff <= lower_sat;
               state_ff <= S_RESP;
            end
            S_CLR: begin
               if (e_ff == init_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  scale_ff <= scale_next;
                  e_ff     <= e_ff + 5'd1;
               end
            end
            S_RESP: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= status_ff;
               rsp_used_ff   <= used_ff;
               rsp_lower_ff  <= lower_ff;
               rsp_hits_ff   <= hits_ff;
               rsp_before_ff <= sum_ff;
               rsp_total_ff  <= total_ff;
               rsp_exp_ff    <= exp_ff;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bins_used    = rsp_used_ff;
   assign rsp_bin_lower    = rsp_lower_ff;
   assign rsp_bin_hits     = rsp_hits_ff;
   assign rsp_hits_before  = rsp_before_ff;
   assign rsp_total_hits   = rsp_total_ff;
   assign rsp_cur_exponent = rsp_exp_ff;

   // checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL)
      else $error("bins in use beyond table depth");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      (scale_ff != 34'd0) && (scale_ff <= SCALE_CAP))
      else $error("scale out of range");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken without going busy");

endmodule
